FILE: hw/rtl/z80ild_pkg.sv
// ----------------------------------------------------------------------------
// z80ild_pkg
// Shared constants and opcode-field helpers for the Z80 instruction length
// decoder.
// ----------------------------------------------------------------------------
package z80ild_pkg;

	localparam logic [7:0] OP_PFX_IX = 8'hDD;
	localparam logic [7:0] OP_PFX_IY = 8'hFD;
	localparam logic [7:0] OP_CB     = 8'hCB;
	localparam logic [7:0] OP_ED     = 8'hED;

	typedef enum logic [1:0] {
		GRP_BASE = 2'd0,
		GRP_CB   = 2'd1,
		GRP_ED   = 2'd2,
		GRP_XCB  = 2'd3
	} group_t;

	typedef enum logic [1:0] {
		IDX_NONE = 2'd0,
		IDX_IX   = 2'd1,
		IDX_IY   = 2'd2,
		IDX_RSVD = 2'd3
	} index_t;

	// Operand bytes that follow a base opcode (x/y/z/p/q decode).
	function automatic logic [1:0] base_extra(input logic [7:0] op, input logic pfx);
		logic [1:0] x;
		logic [2:0] y;
		logic [2:0] z;
		logic [1:0] p;
		logic       q;
		logic [1:0] r;
		x = op[7:6];
		y = op[5:3];
		z = op[2:0];
		p = y[2:1];
		q = y[0];
		r = 2'd0;
		unique case (x)
			2'd0: begin
				unique case (z)
					3'd0: r = (y >= 3'd2) ? 2'd1 : 2'd0;
					3'd1: r = (!q) ? 2'd2 : 2'd0;
					3'd2: r = (p >= 2'd2) ? 2'd2 : 2'd0;
					3'd4, 3'd5: r = (y == 3'd6 && pfx) ? 2'd1 : 2'd0;
					3'd6: r = (y == 3'd6 && pfx) ? 2'd2 : 2'd1;
					default: r = 2'd0;
				endcase
			end
			2'd1: r = (((z == 3'd6) != (y == 3'd6)) && pfx) ? 2'd1 : 2'd0;
			2'd2: r = (z == 3'd6 && pfx) ? 2'd1 : 2'd0;
			default: begin
				unique case (z)
					3'd2, 3'd4: r = 2'd2;
					3'd3: begin
						if (y == 3'd0)
							r = 2'd2;
						else if (y == 3'd2 || y == 3'd3)
							r = 2'd1;
						else
							r = 2'd0;
					end
					3'd5: r = (q && p == 2'd0) ? 2'd2 : 2'd0;
					3'd6: r = 2'd1;
					default: r = 2'd0;
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/z80_instruction_length_decoder.sv
// ----------------------------------------------------------------------------
// z80_instruction_length_decoder
// Finds Z80 instruction boundaries in a byte stream and reports length,
// group, index register and opcode of each completed instruction.
// ----------------------------------------------------------------------------
// Takes one code byte per cycle, starting on an instruction boundary. Each
// byte lands in an input register; one pass of decode logic updates the
// decode state and, on the last byte of an instruction, loads the result
// register. Sustained rate is one byte per clock; the result is registered
// from the decode of its final byte. Bytes that complete no instruction
// keep flowing while a result waits in the result register; a byte that
// completes one waits in the input register until that register is free.
// Lengths saturate at 15 with length_saturated set for long prefix runs.
module z80_instruction_length_decoder
	import z80ild_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       code_valid,
	output logic       code_stall,
	input  logic [7:0] code_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [3:0] instr_length,
	output logic       length_saturated,
	output logic [1:0] instr_group,
	output logic [1:0] index_reg,
	output logic [7:0] main_opcode
);

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_CB    = 3'd1,
		PH_ED    = 3'd2,
		PH_XDISP = 3'd3,
		PH_XOP   = 3'd4,
		PH_OPER  = 3'd5
	} phase_t;

	logic       valid_s1;
	logic [7:0] byte_s1;

	phase_t     phase_q, phase_d;
	logic [3:0] count_q, count_d;
	logic       ovf_q, ovf_d;
	logic [1:0] index_q, index_d;
	logic [1:0] left_q, left_d;
	logic [1:0] hgroup_q, hgroup_d;
	logic [7:0] hop_q, hop_d;

	logic       done;
	logic [1:0] res_group;
	logic [7:0] res_op;
	logic [1:0] extra;
	logic [1:0] left_dec;
	logic       advance;
	logic       out_free;

	logic       res_valid_q;
	logic [3:0] len_q;
	logic       sat_q;
	logic [1:0] grp_q;
	logic [1:0] idx_q;
	logic [7:0] op_q;

	assign out_free   = !res_valid_q || !result_stall;
	assign advance    = valid_s1 && (!done || out_free);
	assign code_stall = valid_s1 && !advance;

	assign extra    = base_extra(byte_s1, index_q != IDX_NONE);
	assign left_dec = (left_q != 2'd0) ? left_q - 2'd1 : 2'd0;

	always_comb begin
		logic [3:0] cnt;
		logic       ovf;
		cnt = (count_q == 4'd15) ? 4'd15 : count_q + 4'd1;
		ovf = ovf_q || (count_q == 4'd15);

		phase_d   = phase_q;
		count_d   = cnt;
		ovf_d     = ovf;
		index_d   = index_q;
		left_d    = left_q;
		hgroup_d  = hgroup_q;
		hop_d     = hop_q;
		done      = 1'b0;
		res_group = GRP_BASE;
		res_op    = byte_s1;

		unique case (phase_q)
			PH_CB: begin
				done      = 1'b1;
				res_group = GRP_CB;
			end
			PH_ED: begin
				if (byte_s1[7:6] == 2'd1 && byte_s1[2:0] == 3'd3) begin
					hgroup_d = GRP_ED;
					hop_d    = byte_s1;
					left_d   = 2'd2;
					phase_d  = PH_OPER;
				end else begin
					done      = 1'b1;
					res_group = GRP_ED;
				end
			end
			PH_XDISP: phase_d = PH_XOP;
			PH_XOP: begin
				done      = 1'b1;
				res_group = GRP_XCB;
			end
			PH_OPER: begin
				left_d = left_dec;
				if (left_dec == 2'd0) begin
					done      = 1'b1;
					res_group = hgroup_q;
					res_op    = hop_q;
				end
			end
			default: begin
				phase_d = PH_START;
				if (byte_s1 == OP_PFX_IX) begin
					index_d = IDX_IX;
				end else if (byte_s1 == OP_PFX_IY) begin
					index_d = IDX_IY;
				end else if (byte_s1 == OP_CB) begin
					phase_d = (index_q != IDX_NONE) ? PH_XDISP : PH_CB;
				end else if (byte_s1 == OP_ED) begin
					phase_d = PH_ED;
				end else if (extra == 2'd0) begin
					done      = 1'b1;
					res_group = GRP_BASE;
				end else begin
					hgroup_d = GRP_BASE;
					hop_d    = byte_s1;
					left_d   = extra;
					phase_d  = PH_OPER;
				end
			end
		endcase

		// return to the instruction boundary
		if (done) begin
			phase_d  = PH_START;
			count_d  = 4'd0;
			ovf_d    = 1'b0;
			index_d  = IDX_NONE;
			left_d   = 2'd0;
			hgroup_d = GRP_BASE;
			hop_d    = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_START;
			count_q     <= 4'd0;
			ovf_q       <= 1'b0;
			index_q     <= IDX_NONE;
			left_q      <= 2'd0;
			hgroup_q    <= GRP_BASE;
			hop_q       <= 8'd0;
			res_valid_q <= 1'b0;
		end else begin
			// input register: load a new beat whenever it drains or is empty
			if (!valid_s1 || advance)
				valid_s1 <= code_valid;
			if (advance) begin
				phase_q  <= phase_d;
				count_q  <= count_d;
				ovf_q    <= ovf_d;
				index_q  <= index_d;
				left_q   <= left_d;
				hgroup_q <= hgroup_d;
				hop_q    <= hop_d;
			end
			if (advance && done)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || advance) && code_valid)
			byte_s1 <= code_byte;
		if (advance && done) begin
			len_q <= count_d == 4'd0 ? ((count_q == 4'd15) ? 4'd15 : count_q + 4'd1) : 4'd0;
			sat_q <= ovf_q || (count_q == 4'd15);
			grp_q <= res_group;
			idx_q <= index_q;
			op_q  <= res_op;
		end
	end

	assign result_valid     = res_valid_q;
	assign instr_length     = len_q;
	assign length_saturated = sat_q;
	assign instr_group      = grp_q;
	assign index_reg        = idx_q;
	assign main_opcode      = op_q;

endmodule

FILE: verif/z80_instruction_length_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// z80_instruction_length_decoder_test
// Self-checking bench for the Z80 instruction length decoder. Code bytes are
// fed as whole instructions (prefix runs, CB, ED, indexed CB, base opcodes
// with their operands) mixed with loose noise bytes. A scoreboard tracks the
// decode state beat by beat and checks every completed-instruction result.
// ----------------------------------------------------------------------------
module z80_instruction_length_decoder_test;
	import z80ild_pkg::*;

	typedef struct packed {
		logic [3:0] length;
		logic       saturated;
		group_t     group;
		index_t     index;
		logic [7:0] opcode;
	} instr_result_t;

	class length_scoreboard;
		typedef enum logic [2:0] {
			AT_BOUNDARY,
			WANT_CB_OP,
			WANT_ED_OP,
			WANT_XDISP,
			WANT_XCB_OP,
			IN_OPERANDS
		} decode_phase_t;

		decode_phase_t phase;
		logic [3:0]    byte_count;
		logic          overflow;
		index_t        index;
		logic [1:0]    operands_left;
		group_t        held_group;
		logic [7:0]    held_opcode;
		instr_result_t expected_q[$];
		int            fails;

		function new();
			fails = 0;
			clear();
		endfunction

		function void clear();
			phase = AT_BOUNDARY;
			byte_count = 4'd0;
			overflow = 1'b0;
			index = IDX_NONE;
			operands_left = 2'd0;
			held_group = GRP_BASE;
			held_opcode = 8'h00;
		endfunction

		// Operand bytes that trail a base opcode, from its x/y/z fields.
		static function logic [1:0] operand_count(logic [7:0] op, bit indexed);
			logic [1:0] x;
			logic [2:0] y;
			logic [2:0] z;
			x = op[7:6];
			y = op[5:3];
			z = op[2:0];
			operand_count = 2'd0;
			case (x)
				2'd0: begin
					case (z)
						3'd0: if (y >= 3'd2) operand_count = 2'd1;
						3'd1: if (!y[0]) operand_count = 2'd2;
						3'd2: if (y[2]) operand_count = 2'd2;
						3'd4, 3'd5: if (y == 3'd6 && indexed) operand_count = 2'd1;
						3'd6: operand_count = (y == 3'd6 && indexed) ? 2'd2 : 2'd1;
						default: ;
					endcase
				end
				// (HL) operand picks up a displacement, HALT does not
				2'd1: if (indexed && ((z == 3'd6) != (y == 3'd6))) operand_count = 2'd1;
				2'd2: if (indexed && z == 3'd6) operand_count = 2'd1;
				default: begin
					case (z)
						3'd2, 3'd4: operand_count = 2'd2;
						3'd3: begin
							if (y == 3'd0)
								operand_count = 2'd2;
							else if (y == 3'd2 || y == 3'd3)
								operand_count = 2'd1;
						end
						3'd5: if (y == 3'd1) operand_count = 2'd2;
						3'd6: operand_count = 2'd1;
						default: ;
					endcase
				end
			endcase
		endfunction

		function void complete(group_t grp, logic [7:0] op);
			instr_result_t r;
			r.length = byte_count;
			r.saturated = overflow;
			r.group = grp;
			r.index = index;
			r.opcode = op;
			expected_q.push_back(r);
			clear();
		endfunction

		function void park(group_t grp, logic [7:0] op, logic [1:0] extra);
			held_group = grp;
			held_opcode = op;
			operands_left = extra;
			phase = IN_OPERANDS;
		endfunction

		// Advance the decode state by one accepted code byte.
		function void note_byte(logic [7:0] b);
			logic [1:0] extra;
			if (byte_count == 4'd15)
				overflow = 1'b1;
			else
				byte_count++;
			case (phase)
				WANT_CB_OP: complete(GRP_CB, b);
				WANT_ED_OP: begin
					if (b[7:6] == 2'b01 && b[2:0] == 3'b011)
						park(GRP_ED, b, 2'd2);
					else
						complete(GRP_ED, b);
				end
				WANT_XDISP: phase = WANT_XCB_OP;
				WANT_XCB_OP: complete(GRP_XCB, b);
				IN_OPERANDS: begin
					if (operands_left != 2'd0) operands_left--;
					if (operands_left == 2'd0) complete(held_group, held_opcode);
				end
				default: begin
					if (b == OP_PFX_IX)
						index = IDX_IX;
					else if (b == OP_PFX_IY)
						index = IDX_IY;
					else if (b == OP_CB)
						phase = (index != IDX_NONE) ? WANT_XDISP : WANT_CB_OP;
					else if (b == OP_ED)
						phase = WANT_ED_OP;
					else begin
						extra = operand_count(b, index != IDX_NONE);
						if (extra == 2'd0)
							complete(GRP_BASE, b);
						else
							park(GRP_BASE, b, extra);
					end
				end
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report_mismatch(string msg);
			if (fails < 50) $display("ERROR at %0t: %s", $time, msg);
			fails++;
		endtask

		task check_result(logic [3:0] len, logic sat, logic [1:0] grp, logic [1:0] idx,
				logic [7:0] op);
			instr_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: len %0d op %02h",
					len, op));
			end else begin
				want = expected_q.pop_front();
				if (len !== want.length)
					report_mismatch($sformatf("instr_length %0d, want %0d", len, want.length));
				if (sat !== want.saturated)
					report_mismatch($sformatf("length_saturated %0b, want %0b", sat,
						want.saturated));
				if (grp !== want.group)
					report_mismatch($sformatf("instr_group %0d, want %0d", grp, want.group));
				if (idx !== want.index)
					report_mismatch($sformatf("index_reg %0d, want %0d", idx, want.index));
				if (op !== want.opcode)
					report_mismatch($sformatf("main_opcode %02h, want %02h", op, want.opcode));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       code_valid;
	logic       code_stall;
	logic [7:0] code_byte;
	logic       result_valid;
	logic       result_stall;
	logic [3:0] instr_length;
	logic       length_saturated;
	logic [1:0] instr_group;
	logic [1:0] index_reg;
	logic [7:0] main_opcode;

	length_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int hold_cycles;
	int bytes_sent;

	logic [7:0] directed_bytes[$] = '{
		8'h00,                                   // NOP
		OP_CB, 8'hFF,                            // SET 7,A
		OP_PFX_IY, OP_CB, 8'h80, 8'h7E,          // BIT 7,(IY-128)
		OP_PFX_IX, OP_ED, 8'h43, 8'hFF, 8'h00,   // ED 16-bit store behind a prefix
		OP_ED, 8'h00,                            // undefined ED opcode
		OP_PFX_IX, 8'h36, 8'h7F, 8'h80,          // LD (IX+d),n
		8'hC3, 8'hAA, 8'h55,                     // JP nn
		8'h76                                    // HALT
	};

	z80_instruction_length_decoder u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.code_valid       (code_valid),
		.code_stall       (code_stall),
		.code_byte        (code_byte),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.instr_length     (instr_length),
		.length_saturated (length_saturated),
		.instr_group      (instr_group),
		.index_reg        (index_reg),
		.main_opcode      (main_opcode)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one byte from a falling edge and hold it until the beat is taken.
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			code_valid <= 1'b0;
			@(negedge clk);
		end
		code_valid <= 1'b1;
		code_byte <= b;
		@(posedge clk);
		while (code_stall) @(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_instruction();
		logic [7:0] seq[$];
		logic [7:0] op;
		int         n_pfx;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			// loose noise with no regard for instruction shape
			repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom));
		end else begin
			pick = $urandom_range(99);
			n_pfx = (pick < 60) ? 0 : (pick < 88) ? 1 : (pick < 94) ? 2 : $urandom_range(3, 20);
			repeat (n_pfx) seq.push_back($urandom_range(1) ? OP_PFX_IX : OP_PFX_IY);
			pick = $urandom_range(99);
			if (pick < 15) begin
				seq.push_back(OP_CB);
				if (n_pfx > 0) seq.push_back(8'($urandom));
				seq.push_back(8'($urandom));
			end else if (pick < 30) begin
				op = 8'($urandom);
				// bias toward the ED forms that carry a 16-bit address
				if ($urandom_range(2) == 0) op = {2'b01, op[5:3], 3'b011};
				seq.push_back(OP_ED);
				seq.push_back(op);
				if (op[7:6] == 2'b01 && op[2:0] == 3'b011)
					repeat (2) seq.push_back(8'($urandom));
			end else begin
				do
					op = 8'($urandom);
				while (op == OP_PFX_IX || op == OP_PFX_IY || op == OP_CB || op == OP_ED);
				seq.push_back(op);
				repeat (length_scoreboard::operand_count(op, n_pfx > 0))
					seq.push_back(8'($urandom));
			end
			// occasionally drop the tail so the next instruction starts mid-stream
			if ($urandom_range(99) < 3) void'(seq.pop_back());
		end
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	// Drop valid and hold until every pending result has come back.
	task automatic wait_for_results();
		code_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	initial begin
		int mode;
		sb = new();
		arst_n = 1'b0;
		code_valid = 1'b0;
		code_byte = 8'h00;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		bytes_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
		wait_for_results();

		for (mode = 0; mode < 5; mode++) begin
			case (mode)
				1: begin
					send_idle_pct = 74;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 74;
				end
				3: begin
					send_idle_pct = 9;
					stall_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			// long receiver hold-off while bytes keep coming, to back up the pipe
			if (mode == 0) hold_cycles = 300;
			@(negedge clk);
			while (bytes_sent < 22 + 330 * (mode + 1)) send_instruction();
			wait_for_results();
		end

		repeat (20) @(posedge clk);
		if (sb.fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: stall at random, or for a counted stretch when asked.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_stall <= 1'b1;
				hold_cycles--;
			end else
				result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(instr_length, length_saturated, instr_group, index_reg,
				main_opcode);
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
